[hdl/tptt_pkg.sv]
// Shared types and constants for the token throughput and phase tracker.
// Used by the channel interfaces and the top level. No dependencies.
package tptt_pkg;

	localparam int COUNT_W = 48;
	localparam int TPS_W = 30;
	localparam int ACTREQ_W = 16;
	localparam int FRAC_BITS = 8;
	localparam int HALF_W = COUNT_W / 2;
	localparam int MUL_W = HALF_W + TPS_W;
	localparam int PROD_W = COUNT_W + TPS_W;
	localparam int NUM_W = PROD_W + FRAC_BITS;
	localparam int HIGH_W = NUM_W - COUNT_W;
	localparam int CNT_W = $clog2(COUNT_W);

	localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(1000000);
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [1:0] ACT_IDLE = 2'd0;
	localparam logic [1:0] ACT_PROMPT = 2'd1;
	localparam logic [1:0] ACT_GEN = 2'd2;

	typedef struct packed {
		logic [COUNT_W-1:0]  prompt_total;
		logic [COUNT_W-1:0]  generation_total;
		logic [ACTREQ_W-1:0] active_requests;
		logic [COUNT_W-1:0]  sample_time;
		logic                clear;
	} sample_t;

	typedef struct packed {
		logic [COUNT_W-1:0] processing_rate;
		logic [COUNT_W-1:0] generation_rate;
		logic [1:0]         activity;
	} result_t;

	// saturating add at the count width
	function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
			input logic [COUNT_W-1:0] b);
		logic [COUNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COUNT_W] ? COUNT_MAX : s[COUNT_W-1:0];
	endfunction

endpackage

[hdl/tptt_sample_if.sv]
// Sample channel: valid/ready handshake carrying one sample item.
// Depends on tptt_pkg for the payload type.
interface tptt_sample_if;
	logic              valid;
	logic              ready;
	tptt_pkg::sample_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/tptt_result_if.sv]
// Result channel: valid/ready handshake carrying one rate/phase item.
// Depends on tptt_pkg for the payload type.
interface tptt_result_if;
	logic              valid;
	logic              ready;
	tptt_pkg::result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/tptt_cfg_if.sv]
// Configuration write channel: valid/ready carrying ticks_per_second.
// Depends on tptt_pkg for the data width.
interface tptt_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [tptt_pkg::TPS_W-1:0]    data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/token_throughput_phase_tracker.sv]
// Token throughput and phase tracker: top level with sequencer and shared
// multiply / divide datapath. Depends on tptt_pkg and the three channel
// interfaces (tptt_sample_if, tptt_result_if, tptt_cfg_if).
//
// Usage:
//   sample  - sink channel; one item per counter sample. Ready is high only
//             while the sequencer is idle.
//   result  - source channel; exactly one item per sample: processing and
//             generation rates (tokens/s, 8 fraction bits, saturated), phase.
//   cfg     - write channel for ticks_per_second; always ready, write it
//             only while no sample is in flight.
// Sequence: a sample that recomputes no rate passes ST_CHECK and ST_FINISH
// into the result register. Each recomputed rate runs on the one shared
// unit: two 24x30 multiply passes, one 78-bit sum, up to 48 restoring
// divide steps. The divide loop dominates the worst case, in which both
// rates are recomputed.
// Reset: all kept sums, flags and rates clear, ticks_per_second returns to
// 1000000, the result register empties.
// Stall: a finished result waits in the output register; the next sample
// is taken meanwhile, but its result holds until the register frees.
module token_throughput_phase_tracker (
	input  logic                   clk,
	input  logic                   arst_n,
	tptt_sample_if.sink            sample,
	tptt_result_if.source          result,
	tptt_cfg_if.sink               cfg
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_SUM,
		ST_DIV,
		ST_FINISH
	} state_t;

	state_t state_q;

	// configuration
	logic [tptt_pkg::TPS_W-1:0] tps_q;

	// captured sample
	tptt_pkg::sample_t in_q;

	// kept tracker state
	logic seen_first_q, was_active_q, gen_begun_q;
	logic [tptt_pkg::COUNT_W-1:0] last_p_q, last_g_q, last_time_q;
	logic [tptt_pkg::COUNT_W-1:0] psum_q, pticks_q, gsum_q, gticks_q;
	logic [tptt_pkg::COUNT_W-1:0] pavg_q, gavg_q;
	logic [1:0] activity_q;
	logic need_p_q, need_g_q;

	// shared rate unit
	logic rate_sel_q;                             // 0 prompt, 1 generation
	logic [tptt_pkg::MUL_W-1:0] lo_q, hi_q;
	logic [tptt_pkg::COUNT_W-1:0] rem_q, num_q;
	logic [tptt_pkg::CNT_W-1:0] div_cnt_q;

	// output register
	logic out_valid_q;
	tptt_pkg::result_t out_q;

	// ---- sample decision logic (used in ST_CHECK) ----
	logic act, restart, accum, gb_next;
	logic [tptt_pkg::COUNT_W-1:0] pd, gd, el;

	assign act = |in_q.active_requests;
	assign pd = in_q.prompt_total - last_p_q;
	assign gd = in_q.generation_total - last_g_q;
	assign el = in_q.sample_time - last_time_q;      // wraps mod 2^48
	assign restart = in_q.clear || !seen_first_q ||
		(in_q.prompt_total < last_p_q) || (in_q.generation_total < last_g_q);
	assign accum = (act || was_active_q) && (el != '0);
	// new activity drops the generating flag; a generation delta sets it
	assign gb_next = (gen_begun_q && !(act && !was_active_q)) || (accum && (gd != '0));

	// ---- shared multiplier and divide step ----
	logic [tptt_pkg::COUNT_W-1:0] tok_sel, tick_sel;
	logic [tptt_pkg::HALF_W-1:0] mul_a;
	logic [tptt_pkg::MUL_W-1:0] mul_p;
	logic [tptt_pkg::PROD_W-1:0] prod;
	logic [tptt_pkg::HIGH_W-1:0] num_high;
	logic [tptt_pkg::COUNT_W-1:0] num_low;
	logic [tptt_pkg::COUNT_W:0] trial;
	logic [tptt_pkg::COUNT_W-1:0] trial_sub;
	logic trial_ok;

	assign tok_sel = rate_sel_q ? gsum_q : psum_q;
	assign tick_sel = rate_sel_q ? gticks_q : pticks_q;
	assign mul_a = (state_q == ST_MUL_HI) ? tok_sel[tptt_pkg::COUNT_W-1:tptt_pkg::HALF_W]
		: tok_sel[tptt_pkg::HALF_W-1:0];
	assign mul_p = tptt_pkg::MUL_W'(mul_a) * tptt_pkg::MUL_W'(tps_q);

	// product times 2^FRAC, split at the quotient width
	assign prod = {hi_q, {tptt_pkg::HALF_W{1'b0}}} + tptt_pkg::PROD_W'(lo_q);
	assign num_high = prod[tptt_pkg::PROD_W-1:tptt_pkg::COUNT_W-tptt_pkg::FRAC_BITS];
	assign num_low = {prod[tptt_pkg::COUNT_W-tptt_pkg::FRAC_BITS-1:0],
		{tptt_pkg::FRAC_BITS{1'b0}}};

	// one restoring step: shift in the next dividend bit, try to subtract;
	// a kept difference is below the divisor, so the count width holds it
	assign trial = {rem_q, num_q[tptt_pkg::COUNT_W-1]};
	assign trial_sub = trial[tptt_pkg::COUNT_W-1:0] - tick_sel;
	assign trial_ok = (trial >= {1'b0, tick_sel});

	assign sample.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign result.valid = out_valid_q;
	assign result.data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tps_q <= tptt_pkg::TPS_RESET;
			in_q <= '0;
			seen_first_q <= 1'b0;
			was_active_q <= 1'b0;
			gen_begun_q <= 1'b0;
			last_p_q <= '0;
			last_g_q <= '0;
			last_time_q <= '0;
			psum_q <= '0;
			pticks_q <= '0;
			gsum_q <= '0;
			gticks_q <= '0;
			pavg_q <= '0;
			gavg_q <= '0;
			activity_q <= tptt_pkg::ACT_IDLE;
			need_p_q <= 1'b0;
			need_g_q <= 1'b0;
			rate_sel_q <= 1'b0;
			lo_q <= '0;
			hi_q <= '0;
			rem_q <= '0;
			num_q <= '0;
			div_cnt_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (cfg.valid) begin
				tps_q <= cfg.data;
			end
			// load a finished item, else drop the result once taken
			if ((state_q == ST_FINISH) && (!out_valid_q || result.ready)) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (sample.valid) begin
						in_q <= sample.data;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					was_active_q <= act;
					last_p_q <= in_q.prompt_total;
					last_g_q <= in_q.generation_total;
					last_time_q <= in_q.sample_time;
					if (restart) begin
						// drop all kept state and restart from this sample
						seen_first_q <= 1'b1;
						gen_begun_q <= 1'b0;
						psum_q <= '0;
						pticks_q <= '0;
						gsum_q <= '0;
						gticks_q <= '0;
						pavg_q <= '0;
						gavg_q <= '0;
						need_p_q <= 1'b0;
						need_g_q <= 1'b0;
						activity_q <= act ? tptt_pkg::ACT_PROMPT : tptt_pkg::ACT_IDLE;
						state_q <= ST_FINISH;
					end else begin
						gen_begun_q <= gb_next;
						activity_q <= !act ? tptt_pkg::ACT_IDLE
							: (gb_next ? tptt_pkg::ACT_GEN : tptt_pkg::ACT_PROMPT);
						need_p_q <= accum && (pd != '0);
						need_g_q <= accum && gb_next;
						if (accum && (pd != '0)) begin
							psum_q <= tptt_pkg::sat_add(psum_q, pd);
							pticks_q <= tptt_pkg::sat_add(pticks_q, el);
						end
						if (accum && gb_next) begin
							gsum_q <= tptt_pkg::sat_add(gsum_q, gd);
							gticks_q <= tptt_pkg::sat_add(gticks_q, el);
						end
						if (accum && (pd != '0)) begin
							rate_sel_q <= 1'b0;
							state_q <= ST_MUL_LO;
						end else if (accum && gb_next) begin
							rate_sel_q <= 1'b1;
							state_q <= ST_MUL_LO;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_MUL_LO: begin
					lo_q <= mul_p;
					state_q <= ST_MUL_HI;
				end
				ST_MUL_HI: begin
					hi_q <= mul_p;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (tptt_pkg::COUNT_W'(num_high) >= tick_sel) begin
						// quotient needs more than the count width: saturate
						if (rate_sel_q) begin
							gavg_q <= tptt_pkg::COUNT_MAX;
						end else begin
							pavg_q <= tptt_pkg::COUNT_MAX;
						end
						if (!rate_sel_q && need_g_q) begin
							rate_sel_q <= 1'b1;
							state_q <= ST_MUL_LO;
						end else begin
							state_q <= ST_FINISH;
						end
					end else begin
						rem_q <= tptt_pkg::COUNT_W'(num_high);
						num_q <= num_low;
						div_cnt_q <= tptt_pkg::CNT_W'(tptt_pkg::COUNT_W - 1);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					// quotient bits shift in as dividend bits shift out
					rem_q <= trial_ok ? trial_sub : trial[tptt_pkg::COUNT_W-1:0];
					num_q <= {num_q[tptt_pkg::COUNT_W-2:0], trial_ok};
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == '0) begin
						if (rate_sel_q) begin
							gavg_q <= {num_q[tptt_pkg::COUNT_W-2:0], trial_ok};
						end else begin
							pavg_q <= {num_q[tptt_pkg::COUNT_W-2:0], trial_ok};
						end
						if (!rate_sel_q && need_g_q) begin
							rate_sel_q <= 1'b1;
							state_q <= ST_MUL_LO;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					// hold until the output register is free
					if (!out_valid_q || result.ready) begin
						out_q.processing_rate <= pavg_q;
						out_q.generation_rate <= gavg_q;
						out_q.activity <= activity_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[tb/sv/tb.sv]
// Self-checking bench for token_throughput_phase_tracker: directed and random
// counter samples, rate and phase checked against a built-in predictor.
// Depends on tptt_pkg and the sample, result and configuration interfaces.
module tb;
	import tptt_pkg::*;

	// Cycles with no accepted item before the run is declared hung; the
	// limit leaves room for the slowest sample plus stalls and drain pauses.
	localparam int STUCK_LIMIT = 5000;
	// Quiet cycles after the last result.
	localparam int TAIL_CYCLES = 120;
	localparam logic [TPS_W-1:0] TPS_TOP = '1;

	logic clk = 1'b0;
	logic arst_n;

	tptt_sample_if sample_ch ();
	tptt_result_if result_ch ();
	tptt_cfg_if    cfg_ch ();

	token_throughput_phase_tracker DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Idle behavior of both sides, changed per traffic phase.
	int send_gap_pct = 0;
	int stall_pct = 0;

	int error_count = 0;
	int results_seen = 0;
	int stuck_cycles = 0;

	// Predictor state: the kept sample, phase flags, sums and last rates.
	logic [TPS_W-1:0]   tps_now = TPS_RESET;
	logic               have_history = 1'b0;
	logic               busy_before = 1'b0;
	logic               gen_started = 1'b0;
	logic [COUNT_W-1:0] prev_prompt = '0;
	logic [COUNT_W-1:0] prev_gen = '0;
	logic [COUNT_W-1:0] prev_time = '0;
	logic [COUNT_W-1:0] prompt_tokens = '0;
	logic [COUNT_W-1:0] prompt_ticks = '0;
	logic [COUNT_W-1:0] gen_tokens = '0;
	logic [COUNT_W-1:0] gen_ticks = '0;
	logic [COUNT_W-1:0] prompt_rate = '0;
	logic [COUNT_W-1:0] gen_rate = '0;

	// Rates and phases still owed by the block, oldest first.
	result_t rate_backlog[$];

	// Random stream state: the counters a well-behaved server would report.
	logic [COUNT_W-1:0] stream_prompt = '0;
	logic [COUNT_W-1:0] stream_gen = '0;
	logic [COUNT_W-1:0] stream_time = '0;
	logic               stream_busy = 1'b0;

	function automatic logic [COUNT_W-1:0] add_clamped(input logic [COUNT_W-1:0] a,
			input logic [COUNT_W-1:0] b);
		logic [COUNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COUNT_W] ? COUNT_MAX : s[COUNT_W-1:0];
	endfunction

	// tokens * tps * 2^FRAC_BITS / ticks, truncated; zero ticks gives zero.
	function automatic logic [COUNT_W-1:0] rate_calc(input logic [COUNT_W-1:0] tokens,
			input logic [COUNT_W-1:0] ticks);
		logic [127:0] num;
		logic [127:0] quo;
		if (ticks == '0)
			return '0;
		num = (128'(tokens) * 128'(tps_now)) << FRAC_BITS;
		quo = num / 128'(ticks);
		return (quo > 128'(COUNT_MAX)) ? COUNT_MAX : quo[COUNT_W-1:0];
	endfunction

	// Advance the predictor by one accepted sample and return its result.
	function automatic result_t track_sample(input sample_t s);
		result_t r;
		logic busy;
		logic [COUNT_W-1:0] pd;
		logic [COUNT_W-1:0] gd;
		logic [COUNT_W-1:0] el;
		busy = (s.active_requests != '0);
		if (s.clear || !have_history || s.prompt_total < prev_prompt ||
				s.generation_total < prev_gen) begin
			// Restart: drop every sum and rate, keep the tick rate register.
			gen_started = 1'b0;
			prompt_tokens = '0;
			prompt_ticks = '0;
			gen_tokens = '0;
			gen_ticks = '0;
			prompt_rate = '0;
			gen_rate = '0;
			r.processing_rate = '0;
			r.generation_rate = '0;
			r.activity = busy ? ACT_PROMPT : ACT_IDLE;
		end else begin
			// A fresh burst of activity must show generation again.
			if (busy && !busy_before)
				gen_started = 1'b0;
			if (busy || busy_before) begin
				pd = s.prompt_total - prev_prompt;
				gd = s.generation_total - prev_gen;
				el = s.sample_time - prev_time;
				if (el != '0) begin
					if (pd != '0) begin
						prompt_tokens = add_clamped(prompt_tokens, pd);
						prompt_ticks = add_clamped(prompt_ticks, el);
						prompt_rate = rate_calc(prompt_tokens, prompt_ticks);
					end
					if (gd != '0)
						gen_started = 1'b1;
					if (gen_started) begin
						gen_tokens = add_clamped(gen_tokens, gd);
						gen_ticks = add_clamped(gen_ticks, el);
						gen_rate = rate_calc(gen_tokens, gen_ticks);
					end
				end
			end
			r.processing_rate = prompt_rate;
			r.generation_rate = gen_rate;
			r.activity = !busy ? ACT_IDLE : (gen_started ? ACT_GEN : ACT_PROMPT);
		end
		have_history = 1'b1;
		busy_before = busy;
		prev_prompt = s.prompt_total;
		prev_gen = s.generation_total;
		prev_time = s.sample_time;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got_v,
			input logic [63:0] want_v);
		$display("t=%0t result %0d: %s got %0h want %0h", $time, results_seen, what,
			got_v, want_v);
		error_count++;
	endtask

	// Record configuration writes and accepted samples at the edge that takes them.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				tps_now = cfg_ch.data;
			if (sample_ch.valid && sample_ch.ready)
				rate_backlog.push_back(track_sample(sample_ch.data));
		end
	end

	// Compare each accepted result with the oldest owed one.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			results_seen++;
			if (rate_backlog.size() == 0) begin
				report_mismatch("result with no sample pending",
					64'(result_ch.data.processing_rate), '0);
			end else begin
				want = rate_backlog.pop_front();
				if (result_ch.data.processing_rate !== want.processing_rate)
					report_mismatch("processing_rate",
						64'(result_ch.data.processing_rate),
						64'(want.processing_rate));
				if (result_ch.data.generation_rate !== want.generation_rate)
					report_mismatch("generation_rate",
						64'(result_ch.data.generation_rate),
						64'(want.generation_rate));
				if (result_ch.data.activity !== want.activity)
					report_mismatch("activity", 64'(result_ch.data.activity),
						64'(want.activity));
			end
		end
	end

	// Stall the result side at the phase's rate.
	always @(posedge clk) begin
		result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Abort when nothing moves on any channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready)) begin
				stuck_cycles = 0;
			end else begin
				stuck_cycles++;
				if (stuck_cycles >= STUCK_LIMIT) begin
					$display("Testbench completed WITH ERRORS");
					$finish;
				end
			end
		end
	end

	function automatic logic [COUNT_W-1:0] rand48();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[COUNT_W-1:0];
	endfunction

	// Counter increment: often none, mostly modest, now and then huge.
	function automatic logic [COUNT_W-1:0] token_step();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return '0;
		if (r < 90)
			return COUNT_W'($urandom_range(1, 5000));
		if (r < 98)
			return COUNT_W'($urandom_range(1, 32'h8000_0000));
		return rand48() >> 4;
	endfunction

	// Time between samples: sometimes none, usually about a second, rarely wrapping.
	function automatic logic [COUNT_W-1:0] elapsed_ticks();
		int r;
		r = $urandom_range(0, 99);
		if (r < 6)
			return '0;
		if (r < 92)
			return COUNT_W'($urandom_range(1, 3000000));
		return rand48();
	endfunction

	function automatic logic [COUNT_W-1:0] start_count();
		if ($urandom_range(0, 1))
			return COUNT_W'($urandom_range(0, 100000));
		return rand48() >> $urandom_range(0, COUNT_W - 1);
	endfunction

	// Build the next random item: mostly a monotonic stream, plus restarts,
	// rollbacks and raw noise.
	task automatic make_sample(output sample_t s);
		int pick;
		pick = $urandom_range(0, 99);
		s = '0;
		if (pick < 4) begin
			s.prompt_total = rand48();
			s.generation_total = rand48();
			s.active_requests = ACTREQ_W'($urandom_range(0, 16'hFFFF));
			s.sample_time = rand48();
			s.clear = 1'($urandom_range(0, 1));
		end else begin
			if (pick < 8) begin
				// New stream, announced by a clear or just a jump.
				stream_prompt = start_count();
				stream_gen = start_count();
				stream_time = rand48();
				s.clear = 1'($urandom_range(0, 1));
			end else if (pick < 11) begin
				// Counter rollback, as after a server restart.
				if ($urandom_range(0, 1))
					stream_prompt = stream_prompt >> 1;
				else
					stream_gen = stream_gen >> 1;
				stream_time = stream_time + elapsed_ticks();
			end else begin
				stream_prompt = add_clamped(stream_prompt, token_step());
				stream_gen = add_clamped(stream_gen, token_step());
				stream_time = stream_time + elapsed_ticks();
			end
			if ($urandom_range(0, 99) < 15)
				stream_busy = !stream_busy;
			s.prompt_total = stream_prompt;
			s.generation_total = stream_gen;
			s.sample_time = stream_time;
			s.active_requests = stream_busy ? ACTREQ_W'($urandom_range(1, 16'hFFFF)) : '0;
		end
	endtask

	// Offer one item; return at the edge that accepts it with valid still high.
	task automatic send_sample(input sample_t s);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.data <= s;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
	endtask

	task automatic send_fields(input logic [COUNT_W-1:0] p, input logic [COUNT_W-1:0] g,
			input logic [ACTREQ_W-1:0] act, input logic [COUNT_W-1:0] t, input logic clr);
		sample_t s;
		s.prompt_total = p;
		s.generation_total = g;
		s.active_requests = act;
		s.sample_time = t;
		s.clear = clr;
		send_sample(s);
	endtask

	// Drop valid and hold until every owed result is back and the block is idle.
	task automatic drain_pipeline();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (rate_backlog.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_tps(input logic [TPS_W-1:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// First sample, prompt then generation, zero elapsed, falling and
	// renewed activity, all at the reset tick rate.
	task automatic test_phase_sequence();
		send_fields(48'd100, 48'd50, 16'd3, 48'd1000, 1'b0);
		send_fields(48'd1100, 48'd50, 16'd1, 48'd2000, 1'b0);
		send_fields(48'd1100, 48'd60, 16'd1, 48'd3000, 1'b0);
		send_fields(48'd1200, 48'd70, 16'd1, 48'd3000, 1'b0);
		send_fields(48'd1300, 48'd80, 16'd0, 48'd4000, 1'b0);
		send_fields(48'd1400, 48'd90, 16'd0, 48'd5000, 1'b0);
		send_fields(48'd1500, 48'd90, 16'hFFFF, 48'd6000, 1'b0);
	endtask

	// Rollback of each counter and clears with all-ones and all-zero fields.
	task automatic test_restarts();
		send_fields(48'd10, 48'd90, 16'd1, 48'd7000, 1'b0);
		send_fields(48'd20, 48'd5, 16'd1, 48'd8000, 1'b0);
		send_fields(COUNT_MAX, COUNT_MAX, 16'hFFFF, COUNT_MAX, 1'b1);
		send_fields('0, '0, 16'd0, '0, 1'b1);
	endtask

	// Saturated rates, timestamp wrap and tick sums driven past full scale.
	task automatic test_extremes();
		send_fields('0, '0, 16'd1, '0, 1'b0);
		send_fields(COUNT_MAX, COUNT_MAX, 16'd1, 48'd1, 1'b0);
		send_fields('0, '0, 16'd1, COUNT_MAX, 1'b1);
		send_fields(48'd10, 48'd10, 16'd1, 48'd5, 1'b0);
		send_fields(48'd20, 48'd20, 16'd1, 48'd4, 1'b0);
		send_fields(48'd20, 48'd30, 16'd1, 48'd3, 1'b0);
	endtask

	task automatic run_stream(input int count);
		sample_t s;
		for (int i = 0; i < count; i++) begin
			make_sample(s);
			send_sample(s);
		end
	endtask

	// Tick rate register: zero, one, one billion, all ones and a random value.
	task automatic test_tick_rates();
		logic [TPS_W-1:0] rates[5];
		rates[0] = '0;
		rates[1] = TPS_W'(1);
		rates[2] = TPS_W'(1000000000);
		rates[3] = TPS_TOP;
		rates[4] = TPS_W'($urandom_range(2, 100000));
		foreach (rates[i]) begin
			drain_pipeline();
			write_tps(rates[i]);
			run_stream(30);
		end
	endtask

	task automatic test_random_traffic(input int gap_pct, input int stall,
			input logic [TPS_W-1:0] rate, input int count);
		drain_pipeline();
		write_tps(rate);
		send_gap_pct = gap_pct;
		stall_pct = stall;
		run_stream(count);
	endtask

	initial begin
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_phase_sequence();
		test_restarts();
		test_extremes();
		test_tick_rates();
		test_random_traffic(0, 0, TPS_RESET, 420);
		test_random_traffic(45, 0, TPS_W'($urandom_range(1, 1000000000)), 420);
		test_random_traffic(0, 45, TPS_W'($urandom), 420);
		test_random_traffic(20, 20, TPS_W'($urandom_range(1, 1000)), 420);

		drain_pipeline();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[token_throughput_phase_tracker.f]
hdl/tptt_pkg.sv
hdl/tptt_sample_if.sv
hdl/tptt_result_if.sv
hdl/tptt_cfg_if.sv
hdl/token_throughput_phase_tracker.sv
tb/sv/tb.sv
